>>> hw/rtl/cwr_pkg.sv
// ----------------------------------------------------------------------------
// cwr_pkg
// Types, status codes and CRC-8 helpers for the CRC-checked word receiver.
// ----------------------------------------------------------------------------
package cwr_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PROTOCOL = 2'd1;
    localparam logic [1:0] ST_LENGTH   = 2'd2;

    localparam logic [0:0] CFG_EXPECTED_BYTES = 1'd0;
    localparam logic [0:0] CFG_STOP_ON_ZERO   = 1'd1;

    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned COUNT_W    = 7;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last;
        logic       bus_fault;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        word;
        logic [1:0]         word_bytes;
        logic               word_checked;
        logic               done_res;
        logic [1:0]         status;
        logic [COUNT_W-1:0] data_count;
    } t_out_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((crc & CRC_MSB) != 8'd0) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [15:0] w);
        return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

endpackage

>>> hw/rtl/crc_checked_word_receiver_core.sv
// ----------------------------------------------------------------------------
// crc_checked_word_receiver_core
// Groups read-transfer bytes into CRC-8 checked 16-bit words with final status.
// ----------------------------------------------------------------------------
// one byte item accepted per cycle while full is low; a result can be popped in
// the cycle after its byte; front-end grouping and crc logic is combinational
// full rises only when all QUEUE_DEPTH result slots hold unread items
// synchronous active-low reset clears transfer state and the result queue,
// and returns expected_bytes to 2 and stop_on_zero to 0
// ----------------------------------------------------------------------------
module crc_checked_word_receiver_core #(
    parameter int unsigned MAX_BYTES   = 64,
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [cwr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  cwr_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output cwr_pkg::t_out_item             o_item
);

    logic               accept;
    logic               res_valid;
    cwr_pkg::t_out_item res;

    assign accept = push && !full;

    cwr_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cwr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .o_full  (full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (o_item)
    );

endmodule

>>> hw/rtl/cwr_queue.sv
// ----------------------------------------------------------------------------
// cwr_queue
// Small result queue between the grouping front end and the output side.
// ----------------------------------------------------------------------------
module cwr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  cwr_pkg::t_out_item   i_data,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_empty,
    output cwr_pkg::t_out_item   o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cwr_pkg::t_out_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (!wr_en && rd_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/cwr_front.sv
// ----------------------------------------------------------------------------
// cwr_front
// Groups received bytes, checks CRC-8, tracks transfer state and forms results.
// ----------------------------------------------------------------------------
module cwr_front #(
    parameter int unsigned MAX_BYTES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [0:0]                         i_cfg_idx,
    input  logic [cwr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_accept,
    input  cwr_pkg::t_in_item                  i_item,
    output logic                               o_res_valid,
    output cwr_pkg::t_out_item                 o_res
);

    localparam int unsigned CAP_INT = (MAX_BYTES < 127) ? MAX_BYTES : 127;
    localparam logic [7:0] COUNT_CAP = 8'(CAP_INT);

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    logic [cwr_pkg::CFG_DATA_W-1:0] r_expected_bytes;
    logic                           r_stop_on_zero;

    logic [1:0]                  r_phase, n_phase;
    logic [15:0]                 r_held, n_held;
    logic [cwr_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_finished, n_finished;
    logic                        r_fault, n_fault;

    logic                        fault_any;
    logic [1:0]                  add_n;
    logic [7:0]                  sum;
    logic [cwr_pkg::COUNT_W-1:0] count_add;
    logic [1:0]                  final_status;
    logic [15:0]                 word_cur;
    logic                        crc_ok;
    logic                        clear;

    assign fault_any = r_fault || i_item.bus_fault;
    assign word_cur  = r_held;
    assign crc_ok    = (cwr_pkg::crc8_word(word_cur) == i_item.rx_byte);

    always_comb begin
        case (r_phase)
            PH_ONE:  add_n = 2'd2;
            PH_TWO:  add_n = 2'd2;
            default: add_n = 2'd1;
        endcase
        sum = {1'b0, r_count} + {6'd0, add_n};
        count_add = (sum > COUNT_CAP) ? COUNT_CAP[cwr_pkg::COUNT_W-1:0]
                                      : sum[cwr_pkg::COUNT_W-1:0];
        if (fault_any || count_add == '0) begin
            final_status = cwr_pkg::ST_PROTOCOL;
        end else if (count_add != r_expected_bytes) begin
            final_status = cwr_pkg::ST_LENGTH;
        end else begin
            final_status = cwr_pkg::ST_OK;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_count     = r_count;
        n_finished  = r_finished;
        n_fault     = r_fault;
        clear       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (r_finished) begin
                clear = i_item.last;
            end else begin
                n_fault = fault_any;
                case (r_phase)
                    PH_ONE: begin
                        n_held  = {r_held[15:8], i_item.rx_byte};
                        n_phase = PH_TWO;
                        if (i_item.last) begin
                            o_res_valid = 1'b1;
                            o_res.word       = {r_held[15:8], i_item.rx_byte};
                            o_res.word_bytes = 2'd2;
                            o_res.done_res   = 1'b1;
                            o_res.status     = final_status;
                            o_res.data_count = count_add;
                            clear = 1'b1;
                        end
                    end
                    PH_TWO: begin
                        n_phase     = PH_NONE;
                        n_held      = '0;
                        o_res_valid = 1'b1;
                        if (!crc_ok) begin
                            o_res.done_res   = 1'b1;
                            o_res.status     = cwr_pkg::ST_PROTOCOL;
                            o_res.data_count = r_count;
                            clear      = i_item.last;
                            n_finished = !i_item.last;
                        end else if (r_stop_on_zero && word_cur == '0) begin
                            n_count = count_add;
                            o_res.word_bytes   = 2'd2;
                            o_res.word_checked = 1'b1;
                            o_res.done_res     = 1'b1;
                            o_res.status       = cwr_pkg::ST_OK;
                            o_res.data_count   = count_add;
                            clear      = i_item.last;
                            n_finished = !i_item.last;
                        end else begin
                            n_count = count_add;
                            o_res.word         = word_cur;
                            o_res.word_bytes   = 2'd2;
                            o_res.word_checked = 1'b1;
                            o_res.done_res     = i_item.last;
                            o_res.status       = i_item.last ? final_status
                                                             : cwr_pkg::ST_OK;
                            o_res.data_count   = count_add;
                            clear = i_item.last;
                        end
                    end
                    default: begin
                        n_held  = {i_item.rx_byte, 8'd0};
                        n_phase = PH_ONE;
                        if (i_item.last) begin
                            o_res_valid = 1'b1;
                            o_res.word       = {i_item.rx_byte, 8'd0};
                            o_res.word_bytes = 2'd1;
                            o_res.done_res   = 1'b1;
                            o_res.status     = final_status;
                            o_res.data_count = count_add;
                            clear = 1'b1;
                        end
                    end
                endcase
            end
            if (clear) begin
                n_phase    = PH_NONE;
                n_held     = '0;
                n_count    = '0;
                n_finished = 1'b0;
                n_fault    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_bytes <= cwr_pkg::CFG_DATA_W'(2);
            r_stop_on_zero   <= 1'b0;
            r_phase          <= PH_NONE;
            r_held           <= '0;
            r_count          <= '0;
            r_finished       <= 1'b0;
            r_fault          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cwr_pkg::CFG_EXPECTED_BYTES: r_expected_bytes <= i_cfg_data;
                    cwr_pkg::CFG_STOP_ON_ZERO:   r_stop_on_zero   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_count    <= n_count;
            r_finished <= n_finished;
            r_fault    <= n_fault;
        end
    end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the crc checked word receiver against a predictor that mirrors its
// transfer state. A short table covers the crc, bus fault, zero stop, early
// close and trailing byte paths. Random transfers then follow, mostly well
// formed groups with occasional bad crc bytes, faults and noise. Register
// settings change between transfers. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_BYTES     = 64;
    localparam int COUNT_CAP     = (MAX_BYTES < 127) ? MAX_BYTES : 127;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 1000;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CRC_RAW, CRC_GOOD, CRC_BAD} t_crc_mode;

    typedef struct packed {
        t_row_kind                      kind;
        logic [0:0]                     reg_idx;
        logic [cwr_pkg::CFG_DATA_W-1:0] reg_val;
        cwr_pkg::t_in_item              byte_in;
        t_crc_mode                      mode;
        logic                           typed;
        cwr_pkg::t_out_item             want;
    } t_step;

    localparam int N_ROWS = 29;
    localparam t_step ROWS [N_ROWS] = '{
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hAB, 1'b1, 1'b0}, CRC_RAW,  1'b1,
          '{16'hAB00, 2'd1, 1'b0, 1'b1, cwr_pkg::ST_LENGTH, 7'd1}},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hBE, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hEF, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b1, 1'b0}, CRC_GOOD, 1'b1,
          '{16'hBEEF, 2'd2, 1'b1, 1'b1, cwr_pkg::ST_OK, 7'd2}},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h12, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h34, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_BAD,  1'b1,
          '{16'h0000, 2'd0, 1'b0, 1'b1, cwr_pkg::ST_PROTOCOL, 7'd0}},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hFF, 1'b0, 1'b1}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h55, 1'b1, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hFF, 1'b0, 1'b1}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'hFF, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b1, 1'b0}, CRC_GOOD, 1'b1,
          '{16'hFFFF, 2'd2, 1'b1, 1'b1, cwr_pkg::ST_PROTOCOL, 7'd2}},
        '{ROW_CFG, cwr_pkg::CFG_STOP_ON_ZERO, 7'd1, '0, CRC_RAW, 1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_GOOD, 1'b1,
          '{16'h0000, 2'd2, 1'b1, 1'b1, cwr_pkg::ST_OK, 7'd2}},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b1}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b1, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_CFG, cwr_pkg::CFG_EXPECTED_BYTES, 7'd127, '0, CRC_RAW, 1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h01, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h02, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_GOOD, 1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h80, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h7F, 1'b1, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_CFG, cwr_pkg::CFG_EXPECTED_BYTES, 7'd0, '0, CRC_RAW, 1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b0, 1'b0}, CRC_RAW,  1'b0, '0},
        '{ROW_ITEM, 1'b0, 7'd0, '{8'h00, 1'b1, 1'b0}, CRC_GOOD, 1'b1,
          '{16'h0000, 2'd2, 1'b1, 1'b1, cwr_pkg::ST_OK, 7'd2}},
        '{ROW_CFG, cwr_pkg::CFG_STOP_ON_ZERO, 7'd0, '0, CRC_RAW, 1'b0, '0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [0:0]                     i_cfg_idx;
    logic [cwr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           push;
    logic                           full;
    cwr_pkg::t_in_item              i_item;
    logic                           empty;
    logic                           pop = 1'b0;
    cwr_pkg::t_out_item             o_item;

    // predictor state
    logic [cwr_pkg::CFG_DATA_W-1:0] cfg_expected = 7'd2;
    logic                           cfg_stop_zero = 1'b0;
    logic [1:0]                     grp_phase = '0;
    logic [15:0]                    grp_held = '0;
    int                             byte_count = 0;
    logic                           xfer_closed = 1'b0;
    logic                           fault_flag = 1'b0;

    cwr_pkg::t_out_item pending_words[$];
    logic               use_typed = 1'b0;
    cwr_pkg::t_out_item typed_word = '0;
    int                 errors = 0;
    int                 idle_pct = 6;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;

    crc_checked_word_receiver_core #(
        .MAX_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_item    (o_item)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_of_word(input logic [15:0] w);
        logic [7:0] c;
        logic       fb;
        c = cwr_pkg::CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            fb = c[7] ^ w[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ cwr_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_transfer();
        grp_phase   = '0;
        grp_held    = '0;
        byte_count  = 0;
        xfer_closed = 1'b0;
        fault_flag  = 1'b0;
    endfunction

    function automatic void add_count(input int n);
        byte_count = (byte_count + n > COUNT_CAP) ? COUNT_CAP : byte_count + n;
    endfunction

    function automatic logic [1:0] final_status();
        if (fault_flag || byte_count == 0) begin
            return cwr_pkg::ST_PROTOCOL;
        end
        if (byte_count != int'(cfg_expected)) begin
            return cwr_pkg::ST_LENGTH;
        end
        return cwr_pkg::ST_OK;
    endfunction

    // returns 1 when the byte produces a result
    function automatic logic absorb_byte(input cwr_pkg::t_in_item it,
                                         output cwr_pkg::t_out_item res);
        logic [15:0] w;
        res = '0;
        if (xfer_closed) begin
            if (it.last) begin
                clear_transfer();
            end
            return 1'b0;
        end
        if (it.bus_fault) begin
            fault_flag = 1'b1;
        end
        if (grp_phase == 2'd2) begin
            w         = grp_held;
            grp_phase = '0;
            grp_held  = '0;
            if (crc8_of_word(w) != it.rx_byte) begin
                res = '{16'h0000, 2'd0, 1'b0, 1'b1, cwr_pkg::ST_PROTOCOL,
                        byte_count[6:0]};
                if (it.last) begin
                    clear_transfer();
                end else begin
                    xfer_closed = 1'b1;
                end
                return 1'b1;
            end
            add_count(2);
            if (cfg_stop_zero && w == 16'h0000) begin
                res = '{16'h0000, 2'd2, 1'b1, 1'b1, cwr_pkg::ST_OK, byte_count[6:0]};
                if (it.last) begin
                    clear_transfer();
                end else begin
                    xfer_closed = 1'b1;
                end
                return 1'b1;
            end
            res = '{w, 2'd2, 1'b1, it.last, it.last ? final_status() : cwr_pkg::ST_OK,
                    byte_count[6:0]};
            if (it.last) begin
                clear_transfer();
            end
            return 1'b1;
        end
        if (grp_phase == 2'd0) begin
            grp_held = {it.rx_byte, 8'h00};
        end else begin
            grp_held[7:0] = it.rx_byte;
        end
        grp_phase = grp_phase + 2'd1;
        if (it.last) begin
            w = (grp_phase == 2'd1) ? {grp_held[15:8], 8'h00} : grp_held;
            add_count(int'(grp_phase));
            res = '{w, grp_phase, 1'b0, 1'b1, final_status(), byte_count[6:0]};
            clear_transfer();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic compare_word(input cwr_pkg::t_out_item want,
                                input cwr_pkg::t_out_item got);
        if (got.word !== want.word) begin
            $error("word: expected %h, got %h", want.word, got.word);
            errors++;
        end
        if (got.word_bytes !== want.word_bytes) begin
            $error("word_bytes: expected %0d, got %0d", want.word_bytes, got.word_bytes);
            errors++;
        end
        if (got.word_checked !== want.word_checked) begin
            $error("word_checked: expected %0d, got %0d", want.word_checked,
                   got.word_checked);
            errors++;
        end
        if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.data_count !== want.data_count) begin
            $error("data_count: expected %0d, got %0d", want.data_count, got.data_count);
            errors++;
        end
    endtask

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        cwr_pkg::t_out_item pred;
        logic               has_res;
        logic               moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                moved = 1'b1;
                if (pending_words.size() == 0) begin
                    $error("unexpected item: word %h status %0d", o_item.word,
                           o_item.status);
                    errors++;
                end else begin
                    compare_word(pending_words.pop_front(), o_item);
                end
            end
            if (push && !full) begin
                moved   = 1'b1;
                has_res = absorb_byte(i_item, pred);
                if (use_typed) begin
                    pending_words.push_back(typed_word);
                end else if (has_res) begin
                    pending_words.push_back(pred);
                end
            end
            if (i_cfg_we) begin
                moved = 1'b1;
                case (i_cfg_idx)
                    cwr_pkg::CFG_EXPECTED_BYTES: cfg_expected = i_cfg_data;
                    cwr_pkg::CFG_STOP_ON_ZERO:   cfg_stop_zero = i_cfg_data[0];
                    default: ;
                endcase
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= idle_pct);
    end

    // entered and left at a falling edge
    task automatic drive(input cwr_pkg::t_in_item it, input t_crc_mode mode,
                         input logic typed, input cwr_pkg::t_out_item want);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        if (mode == CRC_GOOD) begin
            it.rx_byte = crc8_of_word(grp_held);
        end else if (mode == CRC_BAD) begin
            it.rx_byte = crc8_of_word(grp_held) ^ (8'h01 << $urandom_range(7));
        end
        use_typed  = typed;
        typed_word = want;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx,
                             input logic [cwr_pkg::CFG_DATA_W-1:0] val);
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_transfer();
        int                n_groups;
        int                n_trail;
        int                total;
        logic [15:0]       w;
        cwr_pkg::t_in_item it;
        t_crc_mode         mode;
        w = '0;
        if ($urandom_range(99) < 20) begin
            // noise: random bytes, random faults
            total = $urandom_range(1, 10);
            for (int k = 0; k < total; k++) begin
                it.rx_byte   = 8'($urandom);
                it.last      = (k == total - 1);
                it.bus_fault = ($urandom_range(9) == 0);
                drive(it, CRC_RAW, 1'b0, '0);
            end
        end else begin
            if (int'(cfg_expected) <= COUNT_CAP && $urandom_range(1) == 1) begin
                n_groups = cfg_expected / 2;
                n_trail  = cfg_expected % 2;
            end else if ($urandom_range(19) == 0) begin
                n_groups = $urandom_range(22, 40);
                n_trail  = $urandom_range(2);
            end else begin
                n_groups = $urandom_range(0, 6);
                n_trail  = $urandom_range(2);
            end
            if (n_groups == 0 && n_trail == 0) begin
                n_trail = 1;
            end
            total = 3 * n_groups + n_trail;
            for (int k = 0; k < total; k++) begin
                mode = CRC_RAW;
                if (k < 3 * n_groups && k % 3 == 0) begin
                    case ($urandom_range(9))
                        0:       w = 16'h0000;
                        1:       w = 16'hFFFF;
                        default: w = 16'($urandom);
                    endcase
                end
                if (k >= 3 * n_groups) begin
                    it.rx_byte = 8'($urandom);
                end else if (k % 3 == 0) begin
                    it.rx_byte = w[15:8];
                end else if (k % 3 == 1) begin
                    it.rx_byte = w[7:0];
                end else begin
                    it.rx_byte = '0;
                    mode = ($urandom_range(99) < 3) ? CRC_BAD : CRC_GOOD;
                end
                it.last      = (k == total - 1);
                it.bus_fault = ($urandom_range(49) == 0);
                drive(it, mode, 1'b0, '0);
            end
        end
    endtask

    task automatic reconfigure();
        logic [cwr_pkg::CFG_DATA_W-1:0] val;
        case ($urandom_range(6))
            0:       val = 7'd0;
            1:       val = 7'd127;
            2:       val = 7'd64;
            3:       val = 7'($urandom_range(127));
            default: val = 7'(2 * $urandom_range(1, 8));
        endcase
        if ($urandom_range(3) != 0) begin
            write_reg(cwr_pkg::CFG_EXPECTED_BYTES, val);
        end
        if ($urandom_range(1) == 1) begin
            write_reg(cwr_pkg::CFG_STOP_ON_ZERO, 7'($urandom_range(1)));
        end
    endtask

    initial begin
        int first_random;
        int next_cfg;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (ROWS[r].kind == ROW_CFG) begin
                write_reg(ROWS[r].reg_idx, ROWS[r].reg_val);
            end else begin
                drive(ROWS[r].byte_in, ROWS[r].mode, ROWS[r].typed, ROWS[r].want);
            end
        end

        first_random = items_sent;
        next_cfg     = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            // quiet stretch with no idling on either side
            idle_pct = (items_sent - first_random >= 400 &&
                        items_sent - first_random < 650) ? 0 : 6;
            if (items_sent >= next_cfg) begin
                reconfigure();
                next_cfg = items_sent + $urandom_range(60, 140);
            end
            send_transfer();
        end

        push <= 1'b0;
        @(negedge i_clk);
        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
